// ===== src/slr_pkg.sv =====
// slr_pkg: shared types and constants for the slew-limited low-pass ramp.
// Used by slr_ctrl, slr_dp and slew_limited_lowpass_ramp_unit.
package slr_pkg;

  localparam int CMD_W  = 16;
  localparam int TIME_W = 32;
  localparam int RATE_W = 8;
  localparam int SHFT_W = 4;
  localparam int LIM_W  = 4;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_DUE = 2'd1;
  localparam logic [1:0] ST_IDLE    = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_RESYNC_TOL = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_CATCHUP    = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic ready;
    logic load;
    logic clear;
    logic seed;
    logic not_due;
    logic start;
    logic tick;
    logic finish;
    logic push;
  } ctl_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_idle;
    logic need_seed;
    logic not_due;
    logic tick_ok;
  } dp_sts_t;

endpackage

// ===== src/slr_ctrl.sv =====
// slr_ctrl: sequencer for one word: evaluate, catch-up ticks, finish, hand off.
// Depends on slr_pkg for the command and status structs.
module slr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_free,
  input  slr_pkg::dp_sts_t  sts,
  output slr_pkg::ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.is_idle) begin
          cmd.clear = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.need_seed) begin
          cmd.seed  = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.not_due) begin
          cmd.not_due = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_TICK;
        end
      end
      S_TICK: begin
        if (sts.tick_ok) begin
          cmd.tick = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/slr_dp.sv =====
// slr_dp: word latch, rate limiter, shift low-pass filter, config registers, result.
// Depends on slr_pkg; driven by slr_ctrl commands.
module slr_dp #(
  parameter int FILT_FRAC = 8,
  parameter int TICK_MS   = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [slr_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [slr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [slr_pkg::TIME_W-1:0]    in_time_ms,
  input  logic [slr_pkg::CMD_W-1:0]     in_current_cmd,
  input  logic [slr_pkg::CMD_W-1:0]     in_target_cmd,
  input  logic [slr_pkg::CMD_W-1:0]     in_max_cmd,
  input  logic [slr_pkg::CMD_W-1:0]     in_min_cmd,
  input  logic [slr_pkg::RATE_W-1:0]    in_accel_rate,
  input  logic [slr_pkg::SHFT_W-1:0]    in_accel_shift,
  input  logic [slr_pkg::CMD_W-1:0]     in_start_level,
  input  logic [slr_pkg::RATE_W-1:0]    in_decel_rate,
  input  logic [slr_pkg::SHFT_W-1:0]    in_decel_shift,
  input  logic [slr_pkg::CMD_W-1:0]     in_snap_level,
  input  slr_pkg::ctl_cmd_t             cmd,
  output slr_pkg::dp_sts_t              sts,
  output logic [slr_pkg::CMD_W-1:0]     res_command,
  output logic [1:0]                    res_status
);

  localparam int CW = slr_pkg::CMD_W;
  localparam int TW = slr_pkg::TIME_W;
  localparam int FW = CW + FILT_FRAC;
  localparam logic [FW:0]   HALF = (FW+1)'(1) << (FILT_FRAC - 1);
  localparam logic [TW-1:0] TICK = TW'(TICK_MS);

  // latched word
  logic [TW-1:0]                 tm_r;
  logic [CW-1:0]                 cur_r, tgt_r, max_r, min_r, start_r, snap_r;
  logic [slr_pkg::RATE_W-1:0]    arate_r, drate_r;
  logic [slr_pkg::SHFT_W-1:0]    ashift_r, dshift_r;

  // config
  logic [CW-1:0]                 tol_r;
  logic [slr_pkg::LIM_W-1:0]     lim_r;

  // filter state and catch-up bookkeeping
  logic [CW-1:0]                 slew_r, slew_nxt;
  logic [FW-1:0]                 filt_r, filt_nxt;
  logic [TW-1:0]                 last_r, last_nxt;
  logic                          primed_r, primed_nxt;
  logic [TW-1:0]                 rem_r, rem_nxt;
  logic [slr_pkg::LIM_W-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]                 res_cmd_r, res_cmd_nxt;
  logic [1:0]                    res_st_r, res_st_nxt;

  logic                          decel;
  logic [slr_pkg::RATE_W-1:0]    rate;
  logic [slr_pkg::SHFT_W-1:0]    shift;
  logic [FW:0]                   rsum;
  logic [CW:0]                   rnd_wide;
  logic [CW-1:0]                 rnd, diff, seed, lim_tgt, room, step, slew_step;
  logic [CW-1:0]                 oc;
  logic [TW-1:0]                 elapsed;
  logic [FW-1:0]                 goal, fdiff, filt_step;
  logic                          snap_hit;

  always_comb begin
    decel = tgt_r < cur_r;
    rate  = decel ? drate_r : arate_r;
    shift = decel ? dshift_r : ashift_r;

    // round to nearest, saturate at full scale
    rsum     = {1'b0, filt_r} + HALF;
    rnd_wide = rsum[FW:FILT_FRAC];
    rnd      = rnd_wide[CW] ? {CW{1'b1}} : rnd_wide[CW-1:0];
    diff     = (rnd >= cur_r) ? (rnd - cur_r) : (cur_r - rnd);

    seed = cur_r;
    if (!decel) begin
      if (seed < start_r) seed = start_r;
      if (seed < min_r)   seed = min_r;
    end
    if (seed > max_r) seed = max_r;

    elapsed = tm_r - last_r;

    // one tick: slew limiter, then filter toward the new slew value
    lim_tgt = (tgt_r > max_r) ? max_r : tgt_r;
    room    = (slew_r > lim_tgt) ? (slew_r - lim_tgt) : (lim_tgt - slew_r);
    step    = (room > CW'(rate)) ? CW'(rate) : room;
    slew_step = (slew_r > lim_tgt) ? (slew_r - step) : (slew_r + step);
    goal = {slew_step, {FILT_FRAC{1'b0}}};
    if (goal >= filt_r) begin
      fdiff     = (goal - filt_r) >> shift;
      filt_step = filt_r + fdiff;
    end else begin
      fdiff     = (filt_r - goal) >> shift;
      filt_step = filt_r - fdiff;
    end

    // output limits; min floor only while accelerating, max wins
    oc = rnd;
    if (!decel && oc < min_r) oc = min_r;
    if (oc > max_r) oc = max_r;
    snap_hit = (tgt_r == '0) && (oc < snap_r);

    sts.is_idle   = (tgt_r == '0) && (cur_r == '0);
    sts.need_seed = !primed_r || (diff > tol_r);
    sts.not_due   = elapsed < TICK;
    sts.tick_ok   = (rem_r >= TICK) && (cnt_r < lim_r);
  end

  always_comb begin
    slew_nxt    = slew_r;
    filt_nxt    = filt_r;
    primed_nxt  = primed_r;
    last_nxt    = last_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    res_cmd_nxt = res_cmd_r;
    res_st_nxt  = res_st_r;
    if (cmd.clear) begin
      slew_nxt    = '0;
      filt_nxt    = '0;
      primed_nxt  = 1'b0;
      res_cmd_nxt = '0;
      res_st_nxt  = slr_pkg::ST_IDLE;
    end
    if (cmd.seed) begin
      slew_nxt    = seed;
      filt_nxt    = {seed, {FILT_FRAC{1'b0}}};
      last_nxt    = tm_r;
      primed_nxt  = 1'b1;
      res_cmd_nxt = seed;
      res_st_nxt  = slr_pkg::ST_OK;
    end
    if (cmd.not_due) begin
      res_cmd_nxt = '0;
      res_st_nxt  = slr_pkg::ST_NOT_DUE;
    end
    if (cmd.start) begin
      rem_nxt = elapsed;
      cnt_nxt = '0;
    end
    if (cmd.tick) begin
      slew_nxt = slew_step;
      filt_nxt = filt_step;
      rem_nxt  = rem_r - TICK;
      cnt_nxt  = cnt_r + 1'b1;
      last_nxt = last_r + TICK;
    end
    if (cmd.finish) begin
      res_cmd_nxt = snap_hit ? '0 : oc;
      res_st_nxt  = slr_pkg::ST_OK;
      if (snap_hit) begin
        slew_nxt   = '0;
        filt_nxt   = '0;
        primed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tm_r     <= in_time_ms;
      cur_r    <= in_current_cmd;
      tgt_r    <= in_target_cmd;
      max_r    <= in_max_cmd;
      min_r    <= in_min_cmd;
      arate_r  <= in_accel_rate;
      ashift_r <= in_accel_shift;
      start_r  <= in_start_level;
      drate_r  <= in_decel_rate;
      dshift_r <= in_decel_shift;
      snap_r   <= in_snap_level;
    end
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    res_cmd_r <= res_cmd_nxt;
    res_st_r  <= res_st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_r   <= '0;
      filt_r   <= '0;
      last_r   <= '0;
      primed_r <= 1'b0;
    end else begin
      slew_r   <= slew_nxt;
      filt_r   <= filt_nxt;
      last_r   <= last_nxt;
      primed_r <= primed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= CW'(64);
      lim_r <= slr_pkg::LIM_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        slr_pkg::CFG_RESYNC_TOL: tol_r <= cfg_wdata[CW-1:0];
        slr_pkg::CFG_CATCHUP:    lim_r <= cfg_wdata[slr_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign res_command = res_cmd_r;
  assign res_status  = res_st_r;

endmodule

// ===== src/slew_limited_lowpass_ramp_unit.sv =====
// Top level of the slew-limited low-pass ramp: controller, datapath, output register.
// Depends on slr_pkg, slr_ctrl and slr_dp.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per call: timestamp,
//   current and target command, limits and the preselected curve entries.
//   Result channel (out_valid / out_stall) returns exactly one word per input:
//   out_command and out_status (0 updated/reseeded, 1 not due, 2 idle).
//   Config writes (cfg_we, cfg_index, cfg_wdata) set the resync tolerance
//   (index 0) and the catch-up limit (index 1); write only while idle.
// Timing:
//   One word at a time. Idle, reseed and not-due words go from the evaluate state
//   to the done state; an updating word first runs N catch-up ticks (at most the
//   catch-up limit, 15), one tick per cycle through the single limiter/filter
//   step, then a finish step, before the done state. The done state pushes the
//   result into the output register and returns to idle for the next word.
//   A finished result sits in the output register; the next word is accepted
//   while it waits, but that word's result is held until the slot frees up.
// Reset:
//   rst_n clears the filter state, the time base and primed, and loads the
//   config defaults (tolerance 64, catch-up 4). No results are pending after.
module slew_limited_lowpass_ramp_unit #(
  parameter int FILT_FRAC = 8,
  parameter int TICK_MS   = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [slr_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [slr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [slr_pkg::TIME_W-1:0]    in_time_ms,
  input  logic [slr_pkg::CMD_W-1:0]     in_current_cmd,
  input  logic [slr_pkg::CMD_W-1:0]     in_target_cmd,
  input  logic [slr_pkg::CMD_W-1:0]     in_max_cmd,
  input  logic [slr_pkg::CMD_W-1:0]     in_min_cmd,
  input  logic [slr_pkg::RATE_W-1:0]    in_accel_rate,
  input  logic [slr_pkg::SHFT_W-1:0]    in_accel_shift,
  input  logic [slr_pkg::CMD_W-1:0]     in_start_level,
  input  logic [slr_pkg::RATE_W-1:0]    in_decel_rate,
  input  logic [slr_pkg::SHFT_W-1:0]    in_decel_shift,
  input  logic [slr_pkg::CMD_W-1:0]     in_snap_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [slr_pkg::CMD_W-1:0]     out_command,
  output logic [1:0]                    out_status
);

  slr_pkg::ctl_cmd_t              cmd;
  slr_pkg::dp_sts_t               sts;
  logic [slr_pkg::CMD_W-1:0]      res_command;
  logic [1:0]                     res_status;
  logic                           out_free;

  logic                           out_valid_r, out_valid_nxt;
  logic [slr_pkg::CMD_W-1:0]      out_command_r;
  logic [1:0]                     out_status_r;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !cmd.ready;

  slr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  slr_dp #(
    .FILT_FRAC (FILT_FRAC),
    .TICK_MS   (TICK_MS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_time_ms     (in_time_ms),
    .in_current_cmd (in_current_cmd),
    .in_target_cmd  (in_target_cmd),
    .in_max_cmd     (in_max_cmd),
    .in_min_cmd     (in_min_cmd),
    .in_accel_rate  (in_accel_rate),
    .in_accel_shift (in_accel_shift),
    .in_start_level (in_start_level),
    .in_decel_rate  (in_decel_rate),
    .in_decel_shift (in_decel_shift),
    .in_snap_level  (in_snap_level),
    .cmd            (cmd),
    .sts            (sts),
    .res_command    (res_command),
    .res_status     (res_status)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_command_r <= res_command;
      out_status_r  <= res_status;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_command = out_command_r;
  assign out_status  = out_status_r;

  // a new result never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  // one word in flight: after an accept the input side closes
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while busy");

  // a not-due result carries a zero command
  a_not_due_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == slr_pkg::ST_NOT_DUE)) |-> (out_command == '0))
    else $error("not-due result with nonzero command");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for slew_limited_lowpass_ramp_unit: directed table, then random ramps.
// Predicts results with its own limiter/low-pass model or typed table values, under bursty valid/stall traffic.
// Depends on slr_pkg and the RTL under src/.
`timescale 1ns / 100ps

module tb_top;
  import slr_pkg::*;

  localparam int FILT_FRAC       = 8;
  localparam int TICK_MS         = 1;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int SETTLE_CYCLES   = 25;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [CMD_W-1:0]  current_cmd;
    logic [CMD_W-1:0]  target_cmd;
    logic [CMD_W-1:0]  max_cmd;
    logic [CMD_W-1:0]  min_cmd;
    logic [RATE_W-1:0] accel_rate;
    logic [SHFT_W-1:0] accel_shift;
    logic [CMD_W-1:0]  start_level;
    logic [RATE_W-1:0] decel_rate;
    logic [SHFT_W-1:0] decel_shift;
    logic [CMD_W-1:0]  snap_level;
  } ramp_word_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [1:0]       status;
  } ramp_result_t;

  typedef struct {
    ramp_word_t   w;
    bit           track;   // current_cmd follows the last shaped command
    bit           typed;
    ramp_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic in_valid, in_stall;
  logic [TIME_W-1:0] in_time_ms;
  logic [CMD_W-1:0]  in_current_cmd, in_target_cmd, in_max_cmd, in_min_cmd;
  logic [RATE_W-1:0] in_accel_rate, in_decel_rate;
  logic [SHFT_W-1:0] in_accel_shift, in_decel_shift;
  logic [CMD_W-1:0]  in_start_level, in_snap_level;
  logic out_valid, out_stall;
  logic [CMD_W-1:0] out_command;
  logic [1:0]       out_status;

  slew_limited_lowpass_ramp_unit #(
    .FILT_FRAC(FILT_FRAC),
    .TICK_MS  (TICK_MS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_time_ms    (in_time_ms),
    .in_current_cmd(in_current_cmd),
    .in_target_cmd (in_target_cmd),
    .in_max_cmd    (in_max_cmd),
    .in_min_cmd    (in_min_cmd),
    .in_accel_rate (in_accel_rate),
    .in_accel_shift(in_accel_shift),
    .in_start_level(in_start_level),
    .in_decel_rate (in_decel_rate),
    .in_decel_shift(in_decel_shift),
    .in_snap_level (in_snap_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_command   (out_command),
    .out_status    (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ramp state mirror and register copies
  int unsigned ramp_slew, ramp_filter, tol_reg, catchup_reg;
  logic [31:0] ramp_tick_ms;
  bit          ramp_primed;

  ramp_result_t pending_results[$];
  ramp_result_t want_now;
  stim_row_t    directed_rows[$];

  int errors, checked, words_sent, cycles;
  int n_reseed, n_update, n_snap, n_not_due, n_idle;
  int burst_left;
  bit hold_req, hold_active;
  logic [CMD_W-1:0] last_cmd;

  // session of a well-formed ramp
  logic [31:0]       now_ms;
  logic [CMD_W-1:0]  s_max, s_min, s_start, s_snap, s_tgt;
  logic [RATE_W-1:0] s_ar, s_dr;
  logic [SHFT_W-1:0] s_as, s_ds;
  int                sess_left;

  function automatic int unsigned filter_rounded();
    int unsigned r;
    r = (ramp_filter + (1 << (FILT_FRAC - 1))) >> FILT_FRAC;
    return (r > 32'hFFFF) ? 32'hFFFF : r;
  endfunction

  task automatic clear_ramp();
    ramp_slew   = 0;
    ramp_filter = 0;
    ramp_primed = 1'b0;
  endtask

  task automatic shape_command(input ramp_word_t w, output ramp_result_t r);
    bit decel;
    int unsigned rate, sh, cmd, drift, ticks, lim, seed, room, goal;
    int k;
    logic [31:0] elapsed;
    decel = (w.target_cmd < w.current_cmd);
    rate  = decel ? w.decel_rate : w.accel_rate;
    sh    = decel ? w.decel_shift : w.accel_shift;
    r.command = '0;
    r.status  = ST_OK;
    if (w.target_cmd == 0 && w.current_cmd == 0) begin
      clear_ramp();
      r.status = ST_IDLE;
      n_idle++;
    end else begin
      cmd     = filter_rounded();
      drift   = (cmd > w.current_cmd) ? cmd - w.current_cmd : w.current_cmd - cmd;
      elapsed = w.time_ms - ramp_tick_ms;
      if (!ramp_primed || drift > tol_reg) begin
        seed = w.current_cmd;
        if (!decel) begin
          if (seed < w.start_level) seed = w.start_level;
          if (seed < w.min_cmd) seed = w.min_cmd;
        end
        if (seed > w.max_cmd) seed = w.max_cmd;
        ramp_slew    = seed;
        ramp_filter  = seed << FILT_FRAC;
        ramp_tick_ms = w.time_ms;
        ramp_primed  = 1'b1;
        r.command    = seed[15:0];
        n_reseed++;
      end else if (elapsed < TICK_MS) begin
        r.status = ST_NOT_DUE;
        n_not_due++;
      end else begin
        ticks = elapsed / TICK_MS;
        if (ticks > catchup_reg) ticks = catchup_reg;
        ramp_tick_ms = ramp_tick_ms + ticks * TICK_MS;
        lim = (w.target_cmd > w.max_cmd) ? w.max_cmd : w.target_cmd;
        for (k = 0; k < ticks; k++) begin
          if (ramp_slew > lim) begin
            room = ramp_slew - lim;
            ramp_slew -= (room > rate) ? rate : room;
          end else begin
            room = lim - ramp_slew;
            ramp_slew += (room > rate) ? rate : room;
          end
          goal = ramp_slew << FILT_FRAC;
          if (goal >= ramp_filter) ramp_filter += (goal - ramp_filter) >> sh;
          else ramp_filter -= (ramp_filter - goal) >> sh;
        end
        cmd = filter_rounded();
        if (!decel && cmd < w.min_cmd) cmd = w.min_cmd;
        if (cmd > w.max_cmd) cmd = w.max_cmd;
        if (w.target_cmd == 0 && cmd < w.snap_level) begin
          cmd = 0;
          clear_ramp();
          n_snap++;
        end
        r.command = cmd[15:0];
        n_update++;
      end
    end
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_RESYNC_TOL) tol_reg = value;
    else catchup_reg = value[3:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drive one word, wait for it to be taken, predict, then pace the sender
  task automatic send_word(input ramp_word_t w, input bit typed, input ramp_result_t given);
    ramp_result_t r;
    int gap;
    in_valid       <= 1'b1;
    in_time_ms     <= w.time_ms;
    in_current_cmd <= w.current_cmd;
    in_target_cmd  <= w.target_cmd;
    in_max_cmd     <= w.max_cmd;
    in_min_cmd     <= w.min_cmd;
    in_accel_rate  <= w.accel_rate;
    in_accel_shift <= w.accel_shift;
    in_start_level <= w.start_level;
    in_decel_rate  <= w.decel_rate;
    in_decel_shift <= w.decel_shift;
    in_snap_level  <= w.snap_level;
    do @(posedge clk); while (in_stall);
    shape_command(w, r);
    pending_results.push_back(typed ? given : r);
    if (r.status != ST_NOT_DUE) last_cmd = r.command;
    words_sent++;
    burst_left--;
    if (!hold_active && burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_row(input logic [31:0] t, input int cur, tgt, mx, mn, ar, ash, st,
                         input int dr, dsh, sn, input bit track, typed,
                         input int ecmd, input logic [1:0] est);
    stim_row_t row;
    row.w = '{t, cur[15:0], tgt[15:0], mx[15:0], mn[15:0], ar[7:0], ash[3:0], st[15:0],
              dr[7:0], dsh[3:0], sn[15:0]};
    row.track = track;
    row.typed = typed;
    row.want  = '{ecmd[15:0], est};
    directed_rows.push_back(row);
  endtask

  task automatic next_random_word(output ramp_word_t w);
    int k, off, c;
    logic [31:0]  step;
    logic [159:0] noise;
    if (sess_left == 0) begin
      s_max     = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(500, 65535));
      s_min     = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, s_max / 4));
      s_start   = 16'($urandom_range(0, s_max / 2));
      s_ar      = 8'($urandom);
      s_dr      = 8'($urandom);
      s_as      = 4'($urandom);
      s_ds      = 4'($urandom);
      s_snap    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
      s_tgt     = 16'($urandom);
      sess_left = $urandom_range(10, 40);
    end
    sess_left--;
    k = $urandom_range(0, 99);
    if (k < 6) s_tgt = 16'($urandom);
    else if (k < 11) s_tgt = '0;
    else if (k < 20 && last_cmd == 0 && s_tgt == 0) s_tgt = 16'($urandom_range(1, 65535));
    k = $urandom_range(0, 99);
    if (k < 70) step = 1;
    else if (k < 82) step = 0;
    else if (k < 95) step = $urandom_range(2, 20);
    else step = $urandom;
    now_ms = now_ms + step;
    w = '{now_ms, last_cmd, s_tgt, s_max, s_min, s_ar, s_as, s_start, s_dr, s_ds, s_snap};
    k = $urandom_range(0, 99);
    if (k >= 90) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      w = noise[151:0];
    end else if (k >= 78) begin
      // current command right around the resync tolerance
      off = int'(tol_reg) + $urandom_range(0, 4) - 2;
      if (off < 0) off = 0;
      c = ($urandom_range(0, 1) == 1) ? int'(last_cmd) + off : int'(last_cmd) - off;
      if (c < 0) c = 0;
      if (c > 65535) c = 65535;
      w.current_cmd = c[15:0];
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected: command %0d status %0d",
                 $time, out_command, out_status);
        errors++;
      end else begin
        want_now = pending_results.pop_front();
        checked++;
        if (out_command !== want_now.command) begin
          $display("%0t: command mismatch: expected %0d, got %0d",
                   $time, want_now.command, out_command);
          errors++;
        end
        if (out_status !== want_now.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want_now.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("slew_limited_lowpass_ramp_unit test failed");
      $finish;
    end
  end

  // receiver: random stall modes plus one long hold-off on request
  initial begin : receiver
    int mode, mode_left, hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      hold_active = (hold_left > 0);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    ramp_word_t   w;
    ramp_result_t blank;
    int ph, n, drain;
    logic [31:0] tol_next, cat_next;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_time_ms     <= '0;
    in_current_cmd <= '0;
    in_target_cmd  <= '0;
    in_max_cmd     <= '0;
    in_min_cmd     <= '0;
    in_accel_rate  <= '0;
    in_accel_shift <= '0;
    in_start_level <= '0;
    in_decel_rate  <= '0;
    in_decel_shift <= '0;
    in_snap_level  <= '0;
    tol_reg      = 64;
    catchup_reg  = 4;
    ramp_tick_ms = '0;
    clear_ramp();
    last_cmd   = '0;
    blank      = '0;
    burst_left = 5;
    sess_left  = 0;
    now_ms     = '0;

    //      time          cur    tgt    max    min    ar   as start  dr  ds snap  trk typ cmd status
    add_row(32'd0,        0,     0,     0,     0,     0,   0, 0,     0,  0, 0,    0, 1, 0,     ST_IDLE);
    add_row(32'd10,       100,   1000,  5000,  50,    255, 0, 200,   255, 0, 0,   0, 1, 200,   ST_OK);
    add_row(32'd10,       0,     1000,  5000,  50,    255, 0, 200,   255, 0, 0,   1, 1, 0,  ST_NOT_DUE);
    add_row(32'd11,       0,     1000,  5000,  50,    255, 0, 200,   255, 0, 0,   1, 0, 0,     ST_OK);
    add_row(32'd1000,     0,     1000,  5000,  50,    255, 15, 200,  255, 15, 0,  1, 0, 0,     ST_OK);
    add_row(32'd1001,     0,     65535, 3000,  50,    255, 1, 200,   255, 1, 0,   1, 0, 0,     ST_OK);
    add_row(32'd1002,     0,     65535, 3000,  50,    0,   0, 200,   0,  0, 0,    1, 0, 0,     ST_OK);
    add_row(32'd1010,     0,     10,    5000,  50,    10,  0, 200,   255, 2, 0,   1, 0, 0,     ST_OK);
    add_row(32'd1011,     0,     0,     5000,  50,    10,  0, 200,   255, 0, 65535, 1, 0, 0,   ST_OK);
    add_row(32'd1012,     500,   0,     5000,  0,     10,  0, 0,     20, 3, 0,    0, 0, 0,     ST_OK);
    add_row(32'd2000,     60000, 100,   40000, 0,     10,  0, 0,     20, 3, 0,    0, 1, 40000, ST_OK);
    add_row(32'd2001,     100,   5000,  2000,  3000,  10,  0, 0,     20, 3, 0,    0, 1, 2000,  ST_OK);
    add_row(32'd2002,     0,     5000,  2000,  3000,  10,  0, 0,     20, 3, 0,    1, 0, 0,     ST_OK);
    add_row(32'hFFFFFFFE, 100,   65535, 65535, 0,     255, 3, 0,     20, 3, 0,    0, 1, 100,   ST_OK);
    add_row(32'd1,        0,     65535, 65535, 0,     255, 3, 0,     20, 3, 0,    1, 0, 0,     ST_OK);
    add_row(32'hFFFFFFFF, 65535, 65535, 65535, 65535, 255, 15, 65535, 255, 15, 65535, 0, 0, 0, ST_OK);
    add_row(32'd0,        0,     65535, 65535, 65535, 255, 15, 65535, 255, 15, 65535, 1, 0, 0, ST_OK);
    add_row(32'd5,        0,     0,     1000,  0,     100, 4, 0,     100, 4, 0,   0, 1, 0,     ST_IDLE);
    add_row(32'd5,        0,     300,   1000,  0,     100, 4, 0,     100, 4, 0,   0, 1, 0,     ST_OK);
    add_row(32'd9,        0,     300,   1000,  50,    100, 4, 0,     100, 4, 0,   1, 0, 0,     ST_OK);
    add_row(32'd12,       0,     300,   1000,  50,    100, 4, 0,     100, 4, 0,   1, 0, 0,     ST_OK);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      w = directed_rows[i].w;
      if (directed_rows[i].track) w.current_cmd = last_cmd;
      send_word(w, directed_rows[i].typed, directed_rows[i].want);
    end

    for (ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin tol_next = 0; cat_next = 1; end
        1: begin tol_next = 32'hFFFF; cat_next = 15; end
        2: begin tol_next = $urandom_range(0, 200); cat_next = 0; end
        3: begin tol_next = $urandom; cat_next = $urandom_range(1, 15); end
        default: begin tol_next = 64; cat_next = 4; end
      endcase
      write_reg(CFG_RESYNC_TOL, tol_next[15:0]);
      // upper bits of the catch-up word are don't-care
      write_reg(CFG_CATCHUP, {12'($urandom), cat_next[3:0]});
      now_ms    = ($urandom_range(0, 2) == 0) ? 32'hFFFFFF00 : $urandom;
      sess_left = 0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == 15) hold_req = 1'b1;
        next_random_word(w);
        send_word(w, 1'b0, blank);
      end
    end

    in_valid <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors += pending_results.size();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run: %0d words - %0d reseeds, %0d ramp updates (%0d snapped to zero)",
             words_sent, n_reseed, n_update, n_snap);
    $display("  %0d not due, %0d idle; checked %0d result words across 6 register settings",
             n_not_due, n_idle, checked);
    if (errors == 0) $display("slew_limited_lowpass_ramp_unit test passed");
    else $display("slew_limited_lowpass_ramp_unit test failed");
    $finish;
  end

endmodule
